FILE: rtl/pid_moving_average_derivative_unit_macros.svh
// Assertion helpers, clocked on i_clk and held off while i_rst_n is low.
`ifndef PID_MOVING_AVERAGE_DERIVATIVE_UNIT_MACROS_SVH
`define PID_MOVING_AVERAGE_DERIVATIVE_UNIT_MACROS_SVH

// Same-cycle implication.
`define PMAD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pmad: same-cycle check failed");

// Next-cycle implication.
`define PMAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pmad: next-cycle check failed");

`endif

FILE: rtl/pmad_pkg.sv
package pmad_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int HIST_AW    = 4;
    localparam int WIN_W      = 5;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int DT_W       = 31;
    localparam int LIM_W      = 31;
    localparam int DIVD_W     = 49;
    localparam int DIVS_W     = 31;
    localparam int QCNT_W     = 6;
    localparam int SUM_W      = 36;
    localparam int ACC_W      = 48;
    localparam int TOTAL_W    = 50;
    localparam int CFG_IDX_W  = 3;
    localparam int TERM_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_INT_LIMIT = 3'd3,
        CFG_OUT_LIMIT = 3'd4,
        CFG_WINDOW    = 3'd5,
        CFG_USE_EXT   = 3'd6
    } t_cfg_idx;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_ERR    = 13'b0000000000010,
        S_IMUL   = 13'b0000000000100,
        S_IADD   = 13'b0000000001000,
        S_RDIV   = 13'b0000000010000,
        S_WRITE  = 13'b0000000100000,
        S_SUM    = 13'b0000001000000,
        S_ASTART = 13'b0000010000000,
        S_ADIV   = 13'b0000100000000,
        S_AFIN   = 13'b0001000000000,
        S_PMUL   = 13'b0010000000000,
        S_PACC   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_err;
        logic integ_mul;
        logic integ_upd;
        logic rate_start;
        logic rate_store;
        logic sum_step;
        logic avg_start;
        logic avg_store;
        logic term_mul;
        logic term_acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ext_mode;
        logic div_done;
        logic sum_last;
        logic term_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/pmad_if.sv
interface pmad_in_if import pmad_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] target;
    logic        [DT_W-1:0]   time_step;
    logic signed [DATA_W-1:0] external_rate;

    modport source (output valid, position, target, time_step, external_rate, input ready);
    modport sink   (input valid, position, target, time_step, external_rate, output ready);
endinterface

interface pmad_out_if import pmad_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic                     zero_step;

    modport source (output valid, drive, zero_step, input ready);
    modport sink   (input valid, drive, zero_step, output ready);
endinterface

FILE: rtl/pmad_div.sv
// Restoring divider, one quotient bit per cycle.
module pmad_div import pmad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [DIVS_W-1:0] r_rem, n_rem;
    logic [DIVD_W-1:0] r_quot, n_quot;
    logic [DIVS_W-1:0] r_dvs, n_dvs;
    logic [DIVS_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quot[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quot = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem  = fits ? DIVS_W'(trial - {1'b0, r_dvs}) : trial[DIVS_W-1:0];
            n_quot = {r_quot[DIVD_W-2:0], fits};
            n_cnt  = r_cnt + QCNT_W'(1);
            if (r_cnt == QCNT_W'(DIVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: rtl/pmad_dp.sv
module pmad_dp import pmad_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic signed [DATA_W-1:0] i_position,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic [DT_W-1:0]          i_time_step,
    input  logic signed [DATA_W-1:0] i_external_rate,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [DATA_W-1:0] o_drive,
    output logic                     o_zero_step
);
    localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration
    logic signed [DATA_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [LIM_W-1:0]         r_ilim, r_olim;
    logic [WIN_W-1:0]         r_win;
    logic                     r_use_ext;

    // item and state
    logic signed [DATA_W-1:0] r_pos, r_tgt, r_ext;
    logic [DT_W-1:0]          r_dt;
    logic signed [DATA_W-1:0] r_err, r_last_err, r_integ, r_deriv;
    logic                     r_zero, r_neg;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_hist [HIST_DEPTH];
    logic [HIST_AW-1:0]       r_hpos, r_cnt;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [TOTAL_W-1:0] r_total;
    logic [TERM_W-1:0]        r_term;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_drive;
    logic                     r_out_zero;

    logic [WIN_W-1:0]         win_eff;
    logic signed [DATA_W:0]   err_wide, diff;
    logic [DATA_W:0]          diff_mag;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [2*DATA_W-1:0] mul_res;
    logic signed [ACC_W-1:0]  prod_sh, acc, ilim_w;
    logic signed [TOTAL_W-1:0] olim_w;
    logic signed [DATA_W-1:0] integ_clamped, drive_clamped, sample, ext_neg;
    logic [HIST_AW-1:0]       wr_idx;
    logic [WIN_W-1:0]         wr_next;
    logic                     div_start, div_done;
    logic [DIVD_W-1:0]        div_dividend, div_quot;
    logic [DIVS_W-1:0]        div_divisor;

    function automatic logic signed [DATA_W-1:0] sat_quot(input logic [DIVD_W-1:0] q,
                                                          input logic neg);
        logic [DATA_W-1:0] qs;
        qs = (q > DIVD_W'(SMIN)) ? SMIN : q[DATA_W-1:0];
        if (neg) return -qs;
        return (qs == SMIN) ? SMAX : qs;
    endfunction

    assign win_eff = (r_win == '0) ? WIN_W'(1)
                   : (r_win > WIN_W'(HIST_DEPTH)) ? WIN_W'(HIST_DEPTH) : r_win;

    assign err_wide = {r_tgt[DATA_W-1], r_tgt} - {r_pos[DATA_W-1], r_pos};
    assign diff     = {r_err[DATA_W-1], r_err} - {r_last_err[DATA_W-1], r_last_err};
    assign diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;

    // one shared multiplier
    always_comb begin
        if (i_cmd.integ_mul) begin
            mul_a = r_err;
            mul_b = {1'b0, r_dt};
        end else begin
            unique case (r_term)
                2'd1:    begin mul_a = r_integ; mul_b = r_gain_i; end
                2'd2:    begin mul_a = r_deriv; mul_b = r_gain_d; end
                default: begin mul_a = r_err;   mul_b = r_gain_p; end
            endcase
        end
    end
    assign mul_res = mul_a * mul_b;
    assign prod_sh = ACC_W'(r_prod >>> FRAC_BITS);

    // integral update with clamp
    assign ilim_w = ACC_W'({1'b0, r_ilim});
    assign acc    = ACC_W'(r_integ) + prod_sh;
    assign integ_clamped = (acc > ilim_w) ? DATA_W'(ilim_w)
                         : (acc < -ilim_w) ? DATA_W'(-ilim_w) : DATA_W'(acc);

    assign ext_neg = (r_ext == SMIN) ? SMAX : -r_ext;

    // rate sample and ring write slot
    assign sample  = r_zero ? '0 : sat_quot(div_quot, r_neg);
    assign wr_idx  = ({1'b0, r_hpos} >= win_eff) ? '0 : r_hpos;
    assign wr_next = {1'b0, wr_idx} + WIN_W'(1);

    assign olim_w = TOTAL_W'({1'b0, r_olim});
    assign drive_clamped = (r_total > olim_w) ? DATA_W'(olim_w)
                         : (r_total < -olim_w) ? DATA_W'(-olim_w) : DATA_W'(r_total);

    assign div_start    = i_cmd.rate_start | i_cmd.avg_start;
    assign div_dividend = i_cmd.rate_start ? {diff_mag, {FRAC_BITS{1'b0}}}
                                           : DIVD_W'(sum_mag);
    assign div_divisor  = i_cmd.rate_start ? r_dt : DIVS_W'(win_eff);

    pmad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_ilim      <= '1;
            r_olim      <= '1;
            r_win       <= WIN_W'(1);
            r_use_ext   <= 1'b0;
            r_last_err  <= '0;
            r_integ     <= '0;
            r_hpos      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_P:    r_gain_p  <= i_cfg_data;
                    CFG_GAIN_I:    r_gain_i  <= i_cfg_data;
                    CFG_GAIN_D:    r_gain_d  <= i_cfg_data;
                    CFG_INT_LIMIT: r_ilim    <= i_cfg_data[LIM_W-1:0];
                    CFG_OUT_LIMIT: r_olim    <= i_cfg_data[LIM_W-1:0];
                    CFG_WINDOW:    r_win     <= i_cfg_data[WIN_W-1:0];
                    CFG_USE_EXT:   r_use_ext <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.integ_upd) begin
                r_integ    <= integ_clamped;
                r_last_err <= r_err;
            end
            if (i_cmd.rate_store) begin
                r_hist[wr_idx] <= sample;
                r_hpos <= (wr_next >= win_eff) ? '0 : wr_next[HIST_AW-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd.load) begin
            r_pos <= i_position;
            r_tgt <= i_target;
            r_dt  <= i_time_step;
            r_ext <= i_external_rate;
        end
        if (i_cmd.calc_err) begin
            r_err   <= (err_wide[DATA_W] != err_wide[DATA_W-1])
                       ? (err_wide[DATA_W] ? SMIN : SMAX) : err_wide[DATA_W-1:0];
            r_zero  <= (r_dt == '0);
            r_total <= '0;
            r_term  <= '0;
        end
        if (i_cmd.integ_mul || i_cmd.term_mul) begin
            r_prod <= mul_res;
        end
        if (i_cmd.integ_upd && r_use_ext) begin
            r_deriv <= ext_neg;
        end
        if (i_cmd.rate_start) begin
            r_neg <= diff[DATA_W];
        end
        if (i_cmd.rate_store) begin
            r_sum <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.sum_step) begin
            r_sum <= r_sum + SUM_W'(r_hist[r_cnt]);
            r_cnt <= r_cnt + HIST_AW'(1);
        end
        if (i_cmd.avg_start) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (i_cmd.avg_store) begin
            r_deriv <= sat_quot(div_quot, r_neg);
        end
        if (i_cmd.term_acc) begin
            r_total <= r_total + TOTAL_W'(prod_sh);
            r_term  <= r_term + TERM_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_drive <= drive_clamped;
            r_out_zero  <= r_zero;
        end
    end

    assign o_status.ext_mode  = r_use_ext;
    assign o_status.div_done  = div_done;
    assign o_status.sum_last  = ({1'b0, r_cnt} == (win_eff - WIN_W'(1)));
    assign o_status.term_last = (r_term == TERM_W'(2));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;
    assign o_zero_step = r_out_zero;

`include "pid_moving_average_derivative_unit_macros.svh"

    `PMAD_ASSERT_NEXT(a_hpos_in_window, i_cmd.rate_store, ({1'b0, r_hpos} < win_eff))
    `PMAD_ASSERT_NEXT(a_integ_clamped, i_cmd.integ_upd,
        ((ACC_W'(r_integ) <= ilim_w) && (ACC_W'(r_integ) >= -ilim_w)))
    `PMAD_ASSERT_IMPL(a_out_only_on_load, $rose(r_out_valid), $past(i_cmd.out_load))
endmodule

FILE: rtl/pmad_ctrl.sv
module pmad_ctrl import pmad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state        = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.integ_mul = 1'b1;
                n_state         = S_IADD;
            end
            S_IADD: begin
                o_cmd.integ_upd = 1'b1;
                if (i_status.ext_mode) begin
                    n_state = S_PMUL;
                end else begin
                    o_cmd.rate_start = 1'b1;
                    n_state          = S_RDIV;
                end
            end
            S_RDIV: begin
                if (i_status.div_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.rate_store = 1'b1;
                n_state          = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_last) n_state = S_ASTART;
            end
            S_ASTART: begin
                o_cmd.avg_start = 1'b1;
                n_state         = S_ADIV;
            end
            S_ADIV: begin
                if (i_status.div_done) n_state = S_AFIN;
            end
            S_AFIN: begin
                o_cmd.avg_store = 1'b1;
                n_state         = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.term_mul = 1'b1;
                n_state        = S_PACC;
            end
            S_PACC: begin
                o_cmd.term_acc = 1'b1;
                n_state        = i_status.term_last ? S_DONE : S_PMUL;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

FILE: rtl/pid_moving_average_derivative_unit.sv
// Sequence: an accepted item passes S_ERR, S_IMUL and S_IADD; in external-rate mode it then
// goes on to the term multiply-accumulate steps, in averaged mode it first passes the rate
// divide, the ring write, the window sum and the average divide; a held result waits in S_DONE.
// A new item is accepted only in S_IDLE, after the previous result has left S_DONE.
// Reset (synchronous, active low) clears the registers to their defaults, the
// previous error and integral, the 16-entry rate ring and its index; no clearing pass.
module pid_moving_average_derivative_unit import pmad_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    pmad_in_if.sink              i_item,
    pmad_out_if.source           o_result
);
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    pmad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    pmad_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_position      (i_item.position),
        .i_target        (i_item.target),
        .i_time_step     (i_item.time_step),
        .i_external_rate (i_item.external_rate),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_drive         (o_result.drive),
        .o_zero_step     (o_result.zero_step)
    );

    assign i_item.ready = in_ready;
endmodule

FILE: sim/tb_pid_moving_average_derivative_unit.sv
module tb_pid_moving_average_derivative_unit;
    import pmad_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic                     zero_step;
    } t_drive;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    pmad_in_if  in_if ();
    pmad_out_if out_if ();

    pid_moving_average_derivative_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_if),
        .o_result    (out_if)
    );

    // controller image: configuration
    int     kp, ki, kd;
    longint int_lim, out_lim;
    int     win_cfg;
    bit     ext_mode;
    // controller image: state
    int     prev_err;
    int     integ;
    int     rate_ring [HIST_DEPTH];
    int     ring_pos;

    t_drive drive_q [$];
    int     errors;
    bit     idle_on;
    int     hold_cycles;

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sat32(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return int'(x);
    endfunction

    function automatic longint clamp_sym(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic t_drive pid_predict(int pos, int tgt, logic [DT_W-1:0] dt, int ext);
        t_drive r;
        longint dtl, acc, diff, mag, q, sum, total;
        int     err, deriv, sample, w;
        dtl = dt;
        r.zero_step = (dt == 0);
        err = sat32(longint'(tgt) - longint'(pos));
        acc = longint'(integ) + ((longint'(err) * dtl) >>> FRAC_BITS);
        integ = int'(clamp_sym(acc, int_lim));
        if (ext_mode) begin
            deriv = sat32(-longint'(ext));
        end else begin
            w = win_cfg;
            if (w < 1) w = 1;
            if (w > HIST_DEPTH) w = HIST_DEPTH;
            diff = longint'(err) - longint'(prev_err);
            sample = 0;
            if (dtl != 0) begin
                mag = (diff < 0) ? -diff : diff;
                q = (mag <<< FRAC_BITS) / dtl;
                if (q > 64'sd2147483648) q = 64'sd2147483648;
                sample = sat32(diff < 0 ? -q : q);
            end
            if (ring_pos >= w) ring_pos = 0;
            rate_ring[ring_pos] = sample;
            ring_pos++;
            if (ring_pos >= w) ring_pos = 0;
            sum = 0;
            for (int k = 0; k < w; k++) sum += rate_ring[k];
            deriv = sat32(sum / w);
        end
        prev_err = err;
        total = ((longint'(err) * kp) >>> FRAC_BITS)
              + ((longint'(integ) * ki) >>> FRAC_BITS)
              + ((longint'(deriv) * kd) >>> FRAC_BITS);
        r.drive = int'(clamp_sym(total, out_lim));
        return r;
    endfunction

    // mostly small magnitudes so the loop does not sit at the clamps
    function automatic int rand_val();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
            default: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DT_W'($urandom);
            default: return DT_W'($urandom_range(1, 32'h0002_0000));
        endcase
    endfunction

    task automatic send_item(int pos, int tgt, logic [DT_W-1:0] dt, int ext);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.position      <= pos;
        in_if.target        <= tgt;
        in_if.time_step     <= dt;
        in_if.external_rate <= ext;
        do @(posedge i_clk); while (!in_if.ready);
        drive_q.push_back(pid_predict(pos, tgt, dt, ext));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_GAIN_P:    kp = data;
            CFG_GAIN_I:    ki = data;
            CFG_GAIN_D:    kd = data;
            CFG_INT_LIMIT: int_lim = data[LIM_W-1:0];
            CFG_OUT_LIMIT: out_lim = data[LIM_W-1:0];
            CFG_WINDOW:    win_cfg = data[WIN_W-1:0];
            CFG_USE_EXT:   ext_mode = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(int p, int i, int d, int il, int ol, int w, bit e);
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, i);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_INT_LIMIT, il);
        write_reg(CFG_OUT_LIMIT, ol);
        write_reg(CFG_WINDOW, w);
        write_reg(CFG_USE_EXT, e);
    endtask

    task automatic random_gains();
        set_all(rand_val(), rand_val(), rand_val(),
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00FF_FFFF),
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00FF_FFFF),
                $urandom_range(0, 31), $urandom_range(0, 3) == 0);
    endtask

    task automatic test_directed();
        // reset defaults first: all gains zero, drive must be zero
        send_item(32'sh0001_0000, 32'sh0003_0000, 31'h0001_0000, 0);
        wait_drained();
        set_all(32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 4, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 0);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0000_0001, 0);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0, 32'sh7FFF_FFFF);
        send_item(0, 32'sh0002_0000, 31'h0, 0);
        send_item(32'sh0001_0000, 0, 31'h0000_0100, 0);
        send_item(0, 0, 31'h7FFF_FFFF, 0);
        wait_drained();
        // window shrink after the ring index moved past it
        write_reg(CFG_WINDOW, 2);
        send_item(32'sh0005_0000, 0, 31'h0000_4000, 0);
        send_item(0, 32'sh0005_0000, 31'h0000_4000, 0);
        wait_drained();
        write_reg(CFG_WINDOW, 0);
        send_item(32'sh0000_1000, 32'sh0004_0000, 31'h0001_0000, 0);
        wait_drained();
        write_reg(CFG_WINDOW, 31);
        send_item(32'sh0000_1000, 32'sh0004_0000, 31'h0001_0000, 0);
        send_item(32'sh0300_0000, 32'sh8000_0000, 31'h0000_0001, 0);
        wait_drained();
        // external rate, including the most negative value and a zero step
        set_all(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 16, 1'b1);
        send_item(0, 32'sh0001_0000, 31'h0001_0000, 32'sh8000_0000);
        send_item(0, 32'sh0001_0000, 31'h0, 32'sh7FFF_FFFF);
        wait_drained();
        write_reg(CFG_OUT_LIMIT, 32'h0001_0000);
        write_reg(CFG_INT_LIMIT, 32'h0000_8000);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh1234_5678);
        wait_drained();
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            random_gains();
            for (int n = 0; n < per_phase; n++)
                send_item(rand_val(), rand_val(), rand_dt(), rand_val());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        random_gains();
        write_reg(CFG_USE_EXT, 1'b1);
        hold_cycles = 400;
        for (int n = 0; n < 20; n++)
            send_item(rand_val(), rand_val(), rand_dt(), rand_val());
        // sender holds until everything is back, then resumes
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (drive_q.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 20; n++)
            send_item(rand_val(), rand_val(), rand_dt(), rand_val());
        wait_drained();
    endtask

    // result side: random stalls and comparison
    initial begin
        int     stall;
        t_drive exp_r;
        stall = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                if (drive_q.size() == 0) begin
                    $error("unexpected result drive=%0d", out_if.drive);
                    errors++;
                end else begin
                    exp_r = drive_q.pop_front();
                    if (out_if.drive !== exp_r.drive) begin
                        $error("drive expected %0d actual %0d", exp_r.drive, out_if.drive);
                        errors++;
                    end
                    if (out_if.zero_step !== exp_r.zero_step) begin
                        $error("zero_step expected %0b actual %0b",
                               exp_r.zero_step, out_if.zero_step);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        errors      = 0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        kp = 0; ki = 0; kd = 0;
        int_lim = 32'h7FFF_FFFF; out_lim = 32'h7FFF_FFFF;
        win_cfg = 1; ext_mode = 1'b0;
        prev_err = 0; integ = 0; ring_pos = 0;
        foreach (rate_ring[k]) rate_ring[k] = 0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_GAIN_P;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.position      = '0;
        in_if.target        = '0;
        in_if.time_step     = '0;
        in_if.external_rate = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(10, 100);
        idle_on = 1'b0;
        test_random(3, 100);

        wait_drained();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
